FILE: rtl/wpmd_pkg.sv
// wpmd_pkg: shared constants of the windowed presence and motion detector
// field widths, register indexes, reset values and led color codes
// no dependencies
package wpmd_pkg;

  localparam int unsigned WPMD_MAX_WINDOW  = 128;
  localparam int unsigned WPMD_SAMPLE_BITS = 32;

  localparam int unsigned WPMD_IN_W       = 32;
  localparam int unsigned WPMD_THR_W      = 25;
  localparam int unsigned WPMD_WSIZE_W    = 8;
  localparam int unsigned WPMD_OUTL_W     = 8;
  localparam int unsigned WPMD_HOLD_W     = 16;
  localparam int unsigned WPMD_LED_W      = 3;
  localparam int unsigned WPMD_CFG_IDX_W  = 3;
  localparam int unsigned WPMD_CFG_DATA_W = 25;

  localparam logic [WPMD_CFG_IDX_W-1:0] REG_PRESENCE_THR = 3'd0;
  localparam logic [WPMD_CFG_IDX_W-1:0] REG_MOTION_THR   = 3'd1;
  localparam logic [WPMD_CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd2;
  localparam logic [WPMD_CFG_IDX_W-1:0] REG_OUTLIERS     = 3'd3;
  localparam logic [WPMD_CFG_IDX_W-1:0] REG_TRAINING     = 3'd4;
  localparam logic [WPMD_CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd5;

  localparam logic [WPMD_THR_W-1:0]   RST_PRESENCE_THR = 25'd16777;
  localparam logic [WPMD_THR_W-1:0]   RST_MOTION_THR   = 25'd16777;
  localparam logic [WPMD_WSIZE_W-1:0] RST_WINDOW_SIZE  = 8'd5;
  localparam logic [WPMD_OUTL_W-1:0]  RST_OUTLIERS     = 8'd2;
  localparam logic [WPMD_HOLD_W-1:0]  RST_HOLD_MS      = 16'(3 * 1000);

  localparam logic [WPMD_LED_W-1:0] LED_OFF    = 3'd0;
  localparam logic [WPMD_LED_W-1:0] LED_YELLOW = 3'd1;
  localparam logic [WPMD_LED_W-1:0] LED_GREEN  = 3'd2;
  localparam logic [WPMD_LED_W-1:0] LED_BLUE   = 3'd3;
  localparam logic [WPMD_LED_W-1:0] LED_RED    = 3'd4;
  localparam logic [WPMD_LED_W-1:0] LED_WHITE  = 3'd5;

endpackage

FILE: rtl/wpmd_if.sv
// wpmd_if: valid/ready channel interfaces of the detector
// sample input, result output and configuration write channel
// depends on wpmd_pkg
interface wpmd_in_if import wpmd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WPMD_IN_W-1:0] wander_sample;
  logic [WPMD_IN_W-1:0] jitter_sample;
  logic [WPMD_IN_W-1:0] time_ms;

  modport source (output valid, output wander_sample, output jitter_sample,
                  output time_ms, input ready);
  modport sink (input valid, input wander_sample, input jitter_sample,
                input time_ms, output ready);
endinterface

interface wpmd_out_if import wpmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  someone_present;
  logic                  motion_present;
  logic                  led_update;
  logic [WPMD_LED_W-1:0] led_color;

  modport source (output valid, output someone_present, output motion_present,
                  output led_update, output led_color, input ready);
  modport sink (input valid, input someone_present, input motion_present,
                input led_update, input led_color, output ready);
endinterface

interface wpmd_cfg_if import wpmd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [WPMD_CFG_IDX_W-1:0]  index;
  logic [WPMD_CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wpmd_win_ram.sv
// wpmd_win_ram: window sample store, one write port and one registered read port
// holds wander and jitter samples side by side in one word
// no dependencies
module wpmd_win_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/windowed_presence_motion_detector_unit.sv
// windowed_presence_motion_detector_unit: top level of the m-of-n detector
// sequencer, configuration registers, counters and led decision
// depends on wpmd_pkg, wpmd_if and wpmd_win_ram
//
// After reset the block clears its sample windows, one entry a cycle, with
// in_i.ready low; configuration writes are taken at any time and cfg_i.ready
// is always high. An item whose window is not yet full passes through accept
// and write. An item that gives a result passes through accept, write, a
// scan of each window entry, a read tail and a decide step, size being
// window_size with 0 read as 1 and values above MAX_WINDOW read as
// MAX_WINDOW; the result register is loaded in the decide step, which
// repeats while the previous result still waits unaccepted. The window RAM
// has one read port, so the scan reads one entry of both windows per cycle
// and one pair of comparators counts the outliers. The next item may be
// accepted while a result still waits in the output register.
module windowed_presence_motion_detector_unit import wpmd_pkg::*; #(
  parameter int unsigned MAX_WINDOW  = WPMD_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = WPMD_SAMPLE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wpmd_cfg_if.sink   cfg_i,
  wpmd_in_if.sink    in_i,
  wpmd_out_if.source out_o
);

  localparam int unsigned IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SIZE_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WORD_W = 2 * SAMPLE_BITS;
  localparam logic [WPMD_IN_W-1:0] SAMPLE_TOP =
    WPMD_IN_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;

  function automatic logic [SAMPLE_BITS-1:0] clip_sample(input logic [WPMD_IN_W-1:0] v);
    clip_sample = (v > SAMPLE_TOP) ? SAMPLE_BITS'(SAMPLE_TOP) : SAMPLE_BITS'(v);
  endfunction

  // configuration
  logic [WPMD_THR_W-1:0]   pres_thr_q;
  logic [WPMD_THR_W-1:0]   mot_thr_q;
  logic [WPMD_WSIZE_W-1:0] win_size_q;
  logic [WPMD_OUTL_W-1:0]  outliers_q;
  logic                    training_q;
  logic [WPMD_HOLD_W-1:0]  hold_q;

  // sequencer and state
  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_q;
  logic [IDX_W-1:0]  slot_q;
  logic [SIZE_W-1:0] fill_q;
  logic [IDX_W-1:0]  scan_q;
  logic [SIZE_W-1:0] cnt_pres_q;
  logic [SIZE_W-1:0] cnt_mot_q;
  logic              rd_vld_q;
  logic [WPMD_IN_W-1:0] last_motion_q;
  logic [WPMD_IN_W-1:0] last_presence_q;
  logic              blink_q;

  // captured transaction
  logic [SAMPLE_BITS-1:0] wander_q;
  logic [SAMPLE_BITS-1:0] jitter_q;
  logic [WPMD_IN_W-1:0]   time_q;

  // result register
  logic                  out_valid_q;
  logic                  out_pres_q;
  logic                  out_mot_q;
  logic                  out_upd_q;
  logic [WPMD_LED_W-1:0] out_color_q;

  logic [SIZE_W-1:0] size;
  logic [IDX_W-1:0]  slot_eff;
  logic [IDX_W-1:0]  slot_nxt;
  logic [SIZE_W-1:0] fill_nxt;
  logic              fill_short;
  logic              scan_last;
  logic              in_take;
  logic              out_free;
  logic              decide_fire;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] rd_wander;
  logic [SAMPLE_BITS-1:0] rd_jitter;

  logic                  room;
  logic                  human;
  logic [WPMD_IN_W-1:0]  ref_ms;
  logic [WPMD_IN_W-1:0]  elapsed;
  logic                  late;
  logic                  upd;
  logic [WPMD_LED_W-1:0] color;

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_thr_q <= RST_PRESENCE_THR;
      mot_thr_q  <= RST_MOTION_THR;
      win_size_q <= RST_WINDOW_SIZE;
      outliers_q <= RST_OUTLIERS;
      training_q <= 1'b0;
      hold_q     <= RST_HOLD_MS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_PRESENCE_THR: pres_thr_q <= cfg_i.data[WPMD_THR_W-1:0];
        REG_MOTION_THR:   mot_thr_q  <= cfg_i.data[WPMD_THR_W-1:0];
        REG_WINDOW_SIZE:  win_size_q <= cfg_i.data[WPMD_WSIZE_W-1:0];
        REG_OUTLIERS:     outliers_q <= cfg_i.data[WPMD_OUTL_W-1:0];
        REG_TRAINING:     training_q <= cfg_i.data[0];
        REG_HOLD_MS:      hold_q     <= cfg_i.data[WPMD_HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // live window size, slot and fill bookkeeping
  always_comb begin
    if (win_size_q == '0) begin
      size = SIZE_W'(1);
    end else if (32'(win_size_q) > 32'(MAX_WINDOW)) begin
      size = SIZE_W'(MAX_WINDOW);
    end else begin
      size = SIZE_W'(win_size_q);
    end
  end

  assign slot_eff   = (32'(slot_q) >= 32'(size)) ? '0 : slot_q;
  assign slot_nxt   = (32'(slot_eff) + 32'd1 >= 32'(size)) ? '0 : slot_eff + IDX_W'(1);
  assign fill_nxt   = (fill_q < size) ? fill_q + SIZE_W'(1) : size;
  assign fill_short = fill_nxt < size;
  assign scan_last  = (32'(scan_q) + 32'd1) == 32'(size);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_take     = in_i.valid && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;
  assign decide_fire = (state_q == ST_DECIDE) && out_free;

  // window store
  assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : slot_eff;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {wander_q, jitter_q};

  wpmd_win_ram #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  assign rd_wander = ram_rdata[WORD_W-1:SAMPLE_BITS];
  assign rd_jitter = ram_rdata[SAMPLE_BITS-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == IDX_W'(MAX_WINDOW - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = fill_short ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // decision
  assign room    = 32'(cnt_pres_q) >= 32'(outliers_q);
  assign human   = 32'(cnt_mot_q) >= 32'(outliers_q);
  assign ref_ms  = room ? last_motion_q : last_presence_q;
  assign elapsed = time_q - ref_ms;
  assign late    = elapsed > 32'(hold_q);

  always_comb begin
    upd   = 1'b0;
    color = LED_OFF;
    priority if (training_q) begin
      upd   = 1'b1;
      color = blink_q ? LED_OFF : LED_YELLOW;
    end else if (room) begin
      if (human) begin
        upd   = 1'b1;
        color = LED_GREEN;
      end else if (late) begin
        upd   = 1'b1;
        color = LED_BLUE;
      end
    end else begin
      if (late) begin
        upd   = 1'b1;
        color = human ? LED_RED : LED_WHITE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_q           <= '0;
      slot_q          <= '0;
      fill_q          <= '0;
      scan_q          <= '0;
      cnt_pres_q      <= '0;
      cnt_mot_q       <= '0;
      rd_vld_q        <= 1'b0;
      last_motion_q   <= '0;
      last_presence_q <= '0;
      blink_q         <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (state_q == ST_WRITE) begin
        slot_q     <= slot_nxt;
        fill_q     <= fill_nxt;
        scan_q     <= '0;
        cnt_pres_q <= '0;
        cnt_mot_q  <= '0;
      end
      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (rd_vld_q) begin
        if (32'(rd_wander) > 32'(pres_thr_q)) cnt_pres_q <= cnt_pres_q + SIZE_W'(1);
        if (32'(rd_jitter) > 32'(mot_thr_q)) cnt_mot_q <= cnt_mot_q + SIZE_W'(1);
      end
      if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (decide_fire) begin
        out_valid_q <= 1'b1;
        if (training_q) begin
          blink_q <= !blink_q;
        end else if (room) begin
          if (human) last_motion_q <= time_q;
          last_presence_q <= time_q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      wander_q <= clip_sample(in_i.wander_sample);
      jitter_q <= clip_sample(in_i.jitter_sample);
      time_q   <= in_i.time_ms;
    end
    if (decide_fire) begin
      out_pres_q  <= room;
      out_mot_q   <= human;
      out_upd_q   <= upd;
      out_color_q <= color;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.someone_present = out_pres_q;
  assign out_o.motion_present  = out_mot_q;
  assign out_o.led_update      = out_upd_q;
  assign out_o.led_color       = out_color_q;

endmodule

FILE: rtl/wpmd_checker.sv
// wpmd_checker: port-level assertions of the detector top level
// bound to windowed_presence_motion_detector_unit, depends on wpmd_pkg
module wpmd_checker import wpmd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  someone_present_i,
  input logic                  motion_present_i,
  input logic                  led_update_i,
  input logic [WPMD_LED_W-1:0] led_color_i
);

  // a result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable({someone_present_i, motion_present_i, led_update_i, led_color_i}))
    else $error("result payload changed while stalled");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while item in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !led_update_i |-> led_color_i == LED_OFF)
    else $error("led color set without update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> led_color_i <= LED_WHITE)
    else $error("led color code out of range");

endmodule

bind windowed_presence_motion_detector_unit wpmd_checker u_wpmd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .someone_present_i (out_o.someone_present),
  .motion_present_i  (out_o.motion_present),
  .led_update_i      (out_o.led_update),
  .led_color_i       (out_o.led_color)
);

FILE: verif/wpmd_detect_checker.sv
// wpmd_detect_checker: scoreboard for the windowed presence and motion detector
// mirrors register writes, sample windows and led decision, compares every result
// depends on wpmd_pkg and the channel interfaces in wpmd_if
module wpmd_detect_checker import wpmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpmd_cfg_if         cfg_mon_i,
  wpmd_in_if          in_mon_i,
  wpmd_out_if         res_mon_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned result_cnt_o
);

  typedef struct packed {
    logic                  someone;
    logic                  motion;
    logic                  led_update;
    logic [WPMD_LED_W-1:0] led_color;
  } detect_result_t;

  logic [WPMD_THR_W-1:0]       presence_thr;
  logic [WPMD_THR_W-1:0]       motion_thr;
  logic [WPMD_WSIZE_W-1:0]     window_reg;
  logic [WPMD_OUTL_W-1:0]      outliers_reg;
  logic                        training_reg;
  logic [WPMD_HOLD_W-1:0]      hold_reg;
  logic [WPMD_SAMPLE_BITS-1:0] wander_win [WPMD_MAX_WINDOW];
  logic [WPMD_SAMPLE_BITS-1:0] jitter_win [WPMD_MAX_WINDOW];
  int unsigned                 write_slot;
  int unsigned                 fill_count;
  logic [WPMD_IN_W-1:0]        last_motion_ms;
  logic [WPMD_IN_W-1:0]        last_presence_ms;
  logic                        blink_phase;
  detect_result_t              led_expect_q [$];
  int unsigned                 fail_cnt = 0;
  int unsigned                 pending = 0;
  int unsigned                 result_cnt = 0;

  assign fail_cnt_o   = fail_cnt;
  assign pending_o    = pending;
  assign result_cnt_o = result_cnt;

  task automatic clear_model();
    presence_thr     = RST_PRESENCE_THR;
    motion_thr       = RST_MOTION_THR;
    window_reg       = RST_WINDOW_SIZE;
    outliers_reg     = RST_OUTLIERS;
    training_reg     = 1'b0;
    hold_reg         = RST_HOLD_MS;
    for (int i = 0; i < WPMD_MAX_WINDOW; i++) begin
      wander_win[i] = '0;
      jitter_win[i] = '0;
    end
    write_slot       = 0;
    fill_count       = 0;
    last_motion_ms   = '0;
    last_presence_ms = '0;
    blink_phase      = 1'b0;
    led_expect_q.delete();
  endtask

  task automatic apply_reg_write(input logic [WPMD_CFG_IDX_W-1:0] idx,
                                 input logic [WPMD_CFG_DATA_W-1:0] data);
    case (idx)
      REG_PRESENCE_THR: presence_thr = data[WPMD_THR_W-1:0];
      REG_MOTION_THR:   motion_thr   = data[WPMD_THR_W-1:0];
      REG_WINDOW_SIZE:  window_reg   = data[WPMD_WSIZE_W-1:0];
      REG_OUTLIERS:     outliers_reg = data[WPMD_OUTL_W-1:0];
      REG_TRAINING:     training_reg = data[0];
      REG_HOLD_MS:      hold_reg     = data[WPMD_HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_detection(input logic [WPMD_IN_W-1:0] wander,
                                   input logic [WPMD_IN_W-1:0] jitter,
                                   input logic [WPMD_IN_W-1:0] now);
    int unsigned          live;
    int unsigned          some_cnt;
    int unsigned          move_cnt;
    logic                 room;
    logic                 human;
    logic [WPMD_IN_W-1:0] since;
    detect_result_t       res;
    if (window_reg == 0) begin
      live = 1;
    end else if (window_reg > WPMD_MAX_WINDOW) begin
      live = WPMD_MAX_WINDOW;
    end else begin
      live = 32'(window_reg);
    end
    // a shrunk window wraps the slot before the write
    if (write_slot >= live) write_slot = 0;
    wander_win[write_slot] = wander;
    jitter_win[write_slot] = jitter;
    write_slot = (write_slot + 1 >= live) ? 0 : write_slot + 1;
    if (fill_count < live) fill_count++;
    else fill_count = live;
    if (fill_count < live) return;

    some_cnt = 0;
    move_cnt = 0;
    for (int i = 0; i < live; i++) begin
      if (wander_win[i] > presence_thr) some_cnt++;
      if (jitter_win[i] > motion_thr) move_cnt++;
    end
    room  = (some_cnt >= outliers_reg);
    human = (move_cnt >= outliers_reg);

    res = '0;
    res.someone = room;
    res.motion  = human;
    if (training_reg) begin
      res.led_update = 1'b1;
      res.led_color  = blink_phase ? LED_OFF : LED_YELLOW;
      blink_phase    = ~blink_phase;
    end else if (room) begin
      since = now - last_motion_ms;
      if (human) begin
        res.led_update = 1'b1;
        res.led_color  = LED_GREEN;
        last_motion_ms = now;
      end else if (since > hold_reg) begin
        res.led_update = 1'b1;
        res.led_color  = LED_BLUE;
      end
      last_presence_ms = now;
    end else begin
      since = now - last_presence_ms;
      if (since > hold_reg) begin
        res.led_update = 1'b1;
        res.led_color  = human ? LED_RED : LED_WHITE;
      end
    end
    led_expect_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      if (fail_cnt < 100) begin
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
      end
      fail_cnt++;
    end
  endtask

  task automatic check_result();
    detect_result_t want;
    result_cnt++;
    if (led_expect_q.size() == 0) begin
      if (fail_cnt < 100) begin
        $display("%0t: unexpected result transaction, present %0b motion %0b update %0b color %0d",
                 $time, res_mon_i.someone_present, res_mon_i.motion_present,
                 res_mon_i.led_update, res_mon_i.led_color);
      end
      fail_cnt++;
      return;
    end
    want = led_expect_q.pop_front();
    check_field("someone_present", 8'(want.someone), 8'(res_mon_i.someone_present));
    check_field("motion_present", 8'(want.motion), 8'(res_mon_i.motion_present));
    check_field("led_update", 8'(want.led_update), 8'(res_mon_i.led_update));
    check_field("led_color", 8'(want.led_color), 8'(res_mon_i.led_color));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        apply_reg_write(cfg_mon_i.index, cfg_mon_i.data);
      end
      if (res_mon_i.valid && res_mon_i.ready) begin
        check_result();
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_detection(in_mon_i.wander_sample, in_mon_i.jitter_sample, in_mon_i.time_ms);
      end
    end
    pending = led_expect_q.size();
  end

endmodule

FILE: verif/tb_windowed_presence_motion_detector_unit.sv
// tb_windowed_presence_motion_detector_unit: testbench top for the m-of-n detector
// drives register writes and sample transactions under random stalls, gives the verdict
// depends on wpmd_pkg, wpmd_if, the detector rtl and wpmd_detect_checker
module tb_windowed_presence_motion_detector_unit;
  import wpmd_pkg::*;

  localparam logic [WPMD_CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [WPMD_CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned SETTLE_CYCLES   = WPMD_MAX_WINDOW + 8;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS    = 1000;
  localparam logic [WPMD_IN_W-1:0]  SAMPLE_MAX = '1;
  localparam logic [WPMD_THR_W-1:0] THR_ONE    = 25'h100_0000;

  typedef struct packed {
    logic [WPMD_THR_W-1:0]   presence_thr;
    logic [WPMD_THR_W-1:0]   motion_thr;
    logic [WPMD_WSIZE_W-1:0] window;
    logic [WPMD_OUTL_W-1:0]  outliers;
    logic                    training;
    logic [WPMD_HOLD_W-1:0]  hold;
  } detect_settings_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned result_cnt;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_req_cnt;
  int unsigned item_cnt;
  int unsigned phase_cnt;

  wpmd_cfg_if cfg_if ();
  wpmd_in_if  in_if ();
  wpmd_out_if out_if ();

  windowed_presence_motion_detector_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  wpmd_detect_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon_i    (cfg_if),
    .in_mon_i     (in_if),
    .res_mon_i    (out_if),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .result_cnt_o (result_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("%0t: run did not finish in time, %0d results outstanding", $time, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // result receiver, with a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  function automatic int unsigned live_window(input logic [WPMD_WSIZE_W-1:0] w);
    if (w == 0) return 1;
    if (w > WPMD_MAX_WINDOW) return WPMD_MAX_WINDOW;
    return 32'(w);
  endfunction

  function automatic logic [WPMD_CFG_DATA_W-1:0] pad_junk(input logic [WPMD_CFG_DATA_W-1:0] val,
                                                         input int unsigned width);
    logic [WPMD_CFG_DATA_W-1:0] junk;
    junk = WPMD_CFG_DATA_W'($urandom) << width;
    return ($urandom_range(3) == 0) ? (val | junk) : val;
  endfunction

  function automatic detect_settings_t make_settings(input logic [WPMD_THR_W-1:0] pt,
                                                     input logic [WPMD_THR_W-1:0] mt,
                                                     input logic [WPMD_WSIZE_W-1:0] w,
                                                     input logic [WPMD_OUTL_W-1:0] o,
                                                     input logic tr,
                                                     input logic [WPMD_HOLD_W-1:0] h);
    detect_settings_t s;
    s.presence_thr = pt;
    s.motion_thr   = mt;
    s.window       = w;
    s.outliers     = o;
    s.training     = tr;
    s.hold         = h;
    return s;
  endfunction

  function automatic logic [WPMD_THR_W-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return THR_ONE;
      2:       return WPMD_THR_W'($urandom);
      default: return WPMD_THR_W'($urandom_range(0, THR_ONE));
    endcase
  endfunction

  function automatic detect_settings_t pick_settings(input int unsigned idx);
    detect_settings_t s;
    s.presence_thr = pick_threshold();
    s.motion_thr   = pick_threshold();
    if (idx == 3) begin
      s.window = 8'(WPMD_MAX_WINDOW);
    end else if (idx == 9) begin
      s.window = 8'($urandom_range(WPMD_MAX_WINDOW + 1, 255));
    end else begin
      case ($urandom_range(7))
        0:       s.window = '0;
        1, 2:    s.window = 8'($urandom_range(9, 32));
        default: s.window = 8'($urandom_range(1, 8));
      endcase
    end
    case ($urandom_range(6))
      0:       s.outliers = '0;
      1:       s.outliers = 8'($urandom_range(WPMD_MAX_WINDOW, 255));
      2:       s.outliers = 8'($urandom);
      default: s.outliers = 8'($urandom_range(1, live_window(s.window) + 1));
    endcase
    s.training = ($urandom_range(4) == 0);
    case ($urandom_range(4))
      0:       s.hold = '0;
      1:       s.hold = '1;
      default: s.hold = 16'($urandom_range(1, 5000));
    endcase
    return s;
  endfunction

  function automatic logic [WPMD_IN_W-1:0] pick_sample(input logic [WPMD_THR_W-1:0] thr);
    case ($urandom_range(10))
      0:       return '0;
      1:       return SAMPLE_MAX;
      2:       return $urandom;
      default: return $urandom_range(0, 2 * thr + 16);
    endcase
  endfunction

  function automatic logic [WPMD_IN_W-1:0] pick_step(input logic [WPMD_HOLD_W-1:0] hold);
    case ($urandom_range(8))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom_range(0, 2 * hold + 2);
    endcase
  endfunction

  task automatic push_sample(input logic [WPMD_IN_W-1:0] wander,
                             input logic [WPMD_IN_W-1:0] jitter,
                             input logic [WPMD_IN_W-1:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.wander_sample <= wander;
    in_if.jitter_sample <= jitter;
    in_if.time_ms       <= now;
    do @(posedge clk_i); while (!in_if.ready);
    item_cnt++;
  endtask

  task automatic write_reg(input logic [WPMD_CFG_IDX_W-1:0] idx,
                           input logic [WPMD_CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // drain all results and let the block go quiet before touching registers
  task automatic apply_settings(input detect_settings_t s);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_PRESENCE_THR, s.presence_thr);
    write_reg(REG_MOTION_THR, s.motion_thr);
    write_reg(REG_WINDOW_SIZE, pad_junk(WPMD_CFG_DATA_W'(s.window), WPMD_WSIZE_W));
    write_reg(REG_OUTLIERS, pad_junk(WPMD_CFG_DATA_W'(s.outliers), WPMD_OUTL_W));
    write_reg(REG_TRAINING, pad_junk(WPMD_CFG_DATA_W'(s.training), 1));
    write_reg(REG_HOLD_MS, pad_junk(WPMD_CFG_DATA_W'(s.hold), WPMD_HOLD_W));
    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, WPMD_CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
    phase_cnt++;
  endtask

  initial begin
    detect_settings_t     s;
    int unsigned          rand_items;
    int unsigned          idx;
    int unsigned          n;
    int unsigned          drain;
    logic [WPMD_IN_W-1:0] now_ms;
    src_idle_pct  = 16;
    sink_idle_pct = 51;
    hold_req_cnt  = 0;
    item_cnt      = 0;
    phase_cnt     = 0;
    rst_ni              <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    in_if.valid         <= 1'b0;
    in_if.wander_sample <= '0;
    in_if.jitter_sample <= '0;
    in_if.time_ms       <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, window of five
    push_sample('0, '0, '0);
    push_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    push_sample(32'd16777, 32'd16778, 32'd1000);
    push_sample(32'd16778, 32'd16777, 32'd2000);
    push_sample(SAMPLE_MAX, '0, 32'd3500);
    push_sample('0, SAMPLE_MAX, 32'd7000);

    // every non-training led decision, hold boundary and timestamp wrap
    apply_settings(make_settings(THR_ONE, THR_ONE, 8'd1, 8'd1, 1'b0, 16'd100));
    push_sample(SAMPLE_MAX, SAMPLE_MAX, 32'd10);
    push_sample(SAMPLE_MAX, '0, 32'd50);
    push_sample(SAMPLE_MAX, '0, 32'd200);
    push_sample('0, SAMPLE_MAX, 32'd250);
    push_sample('0, SAMPLE_MAX, 32'd400);
    push_sample('0, '0, 32'd600);
    push_sample(32'(THR_ONE), 32'(THR_ONE) + 1, 32'hFFFF_FFF0);
    push_sample(SAMPLE_MAX, SAMPLE_MAX, 32'd5);
    push_sample(SAMPLE_MAX, '0, 32'h69);
    push_sample(SAMPLE_MAX, '0, 32'h6A);

    // training blink, zero window, zero outliers needed
    apply_settings(make_settings('1, '1, 8'd0, 8'd0, 1'b1, '1));
    push_sample(SAMPLE_MAX, '0, 32'd1);
    push_sample('0, SAMPLE_MAX, 32'd2);
    push_sample(SAMPLE_MAX, SAMPLE_MAX, 32'd3);
    push_sample('0, '0, 32'd4);

    // window growth waits for new entries, shrink gives a result at once
    apply_settings(make_settings('0, '0, 8'd3, 8'd3, 1'b0, '0));
    push_sample(32'd1, '0, 32'd100);
    push_sample(32'd1, 32'd1, 32'd101);
    push_sample(32'd1, 32'd1, 32'd102);
    apply_settings(make_settings('0, '0, 8'd2, 8'd2, 1'b0, '0));
    push_sample('0, 32'd1, 32'd103);
    push_sample(32'd1, 32'd1, 32'd104);

    rand_items = 0;
    idx        = 0;
    while (rand_items < RANDOM_ITEMS) begin
      s = pick_settings(idx);
      apply_settings(s);
      if (idx == 1 || idx == 6) hold_req_cnt++;
      n = (live_window(s.window) > 32) ? live_window(s.window) + $urandom_range(20, 40)
                                       : $urandom_range(30, 80);
      now_ms = $urandom;
      repeat (n) begin
        if (rand_items >= 2 * RANDOM_ITEMS / 3) begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end else if (rand_items >= RANDOM_ITEMS / 3) begin
          src_idle_pct  = 51;
          sink_idle_pct = 16;
        end
        push_sample(pick_sample(s.presence_thr), pick_sample(s.motion_thr), now_ms);
        now_ms = now_ms + pick_step(s.hold);
        rand_items++;
      end
      idx++;
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (pending != 0 && drain < 50000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run covered %0d sample transactions and %0d results over %0d register settings",
             item_cnt, result_cnt, phase_cnt);
    $display("including training blink, hold-off edges, window sizes 0 to 255 and output stalls");
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
